// ===== src/pcsg_pkg.sv =====
package pcsg_pkg;

   localparam int CMD_W = 2;
   localparam int PCR_W = 33;
   localparam int PID_W = 13;
   localparam int CUT_W = 29;

   // elapsed ticks against cut_ms*90: products reach 36 bits, compare needs a sign bit
   localparam int X90_W = 36;
   localparam int SUB_W = 37;

   localparam int CUT_DEPTH_DEFAULT = 64;

   localparam logic [CUT_W-1:0] OPEN_END_MS = CUT_W'(360000000);

   localparam logic [CMD_W-1:0] CMD_PROCESS = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

   // 90 = 64 + 16 + 8 + 2
   function automatic logic [X90_W-1:0] times90(input logic [CUT_W-1:0] v);
      logic [X90_W-1:0] w;
      w = X90_W'(v);
      return (w << 6) + (w << 4) + (w << 3) + (w << 1);
   endfunction

endpackage

// ===== src/pcr_cut_segment_gate_top.sv =====
// Channel  Direction  Handshake           Payload
// req      in         req_valid/stall     command, pcr_valid, pcr_value, packet_id, cut_time_ms
// rsp      out        rsp_valid/stall     pass_item, out_packet_id, adjusted_pcr
// csr      in         csr_valid/ready     cut_enable
//
// Load, restart and unknown commands give no result.
// A process item with cutting off or no timestamp goes straight to the output state,
// a backward step from the origin check; others walk each interval passed over, paced
// by the single table read port and the one shared times-90 / subtract unit.
// Synchronous active-high reset clears control state; the cut table holds garbage.
// A stalled result sits in the output register while the next item is taken.
module pcr_cut_segment_gate_top #(
   parameter int CUT_DEPTH = pcsg_pkg::CUT_DEPTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,

   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [pcsg_pkg::CMD_W-1:0]  req_command,
   input  logic                        req_pcr_valid,
   input  logic [pcsg_pkg::PCR_W-1:0]  req_pcr_value,
   input  logic [pcsg_pkg::PID_W-1:0]  req_packet_id,
   input  logic [pcsg_pkg::CUT_W-1:0]  req_cut_time_ms,

   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_pass_item,
   output logic [pcsg_pkg::PID_W-1:0]  rsp_out_packet_id,
   output logic [pcsg_pkg::PCR_W-1:0]  rsp_adjusted_pcr,

   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic                        csr_cut_enable
);
   import pcsg_pkg::*;

   localparam int AW = (CUT_DEPTH > 1) ? $clog2(CUT_DEPTH) : 1;
   localparam int CW = $clog2(CUT_DEPTH + 2);

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_ORIGIN    = 4'd1;
   localparam logic [3:0] S_ELAPSED   = 4'd2;
   localparam logic [3:0] S_RD_END    = 4'd3;
   localparam logic [3:0] S_CMP_END   = 4'd4;
   localparam logic [3:0] S_ACC       = 4'd5;
   localparam logic [3:0] S_RD_START  = 4'd6;
   localparam logic [3:0] S_CMP_START = 4'd7;
   localparam logic [3:0] S_ADJ       = 4'd8;
   localparam logic [3:0] S_OUT       = 4'd9;

   logic [3:0]       state_ff, state_in;
   logic             cut_en_ff, cut_en_in;
   logic [CW-1:0]    load_cnt_ff, load_cnt_in;
   logic [CW-1:0]    read_idx_ff, read_idx_in;
   logic             origin_seen_ff, origin_seen_in;
   logic [PCR_W-1:0] origin_ff, origin_in;
   logic [PCR_W-1:0] prev_ff, prev_in;
   logic [CUT_W-1:0] total_ff, total_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic [PCR_W-1:0] pcr_ff, pcr_in;
   logic [PID_W-1:0] pid_ff, pid_in;
   logic [PCR_W-1:0] elapsed_ff, elapsed_in;
   logic [CUT_W-1:0] end_ff, end_in;
   logic             end_open_ff, end_open_in;
   logic             res_pass_ff, res_pass_in;
   logic [PCR_W-1:0] res_adj_ff, res_adj_in;
   logic             rsp_pass_ff;
   logic [PID_W-1:0] rsp_pid_ff;
   logic [PCR_W-1:0] rsp_adj_ff;

   logic [CUT_W-1:0] cut_mem [CUT_DEPTH];
   logic [CUT_W-1:0] rd_data_ff;
   logic             wr_en, rd_en, out_load;
   logic [AW-1:0]    wr_addr, rd_addr;

   logic [CUT_W-1:0] x90_op;
   logic [X90_W-1:0] x90;
   logic [SUB_W-1:0] sub_a, sub_b, diff;
   logic [CW:0]      limit;
   logic [CW-1:0]    idx_next;
   logic [CUT_W-1:0] end_val;
   logic             accept;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign limit    = {1'b0, load_cnt_ff} + (CW+1)'(load_cnt_ff[0]);
   assign idx_next = read_idx_ff + CW'(1);
   assign end_val  = end_open_ff ? OPEN_END_MS : rd_data_ff;

   // shared times-90 and subtract unit
   always_comb begin
      x90_op = total_ff;
      sub_a  = SUB_W'(pcr_ff);
      sub_b  = '0;
      unique case (state_ff)
         S_ORIGIN: begin
            sub_b = SUB_W'(origin_seen_ff ? prev_ff : pcr_ff);
         end
         S_ELAPSED: begin
            sub_b = SUB_W'(origin_ff);
         end
         S_CMP_END: begin
            x90_op = end_val;
            sub_a  = SUB_W'(elapsed_ff);
         end
         S_CMP_START: begin
            x90_op = rd_data_ff;
            sub_a  = SUB_W'(elapsed_ff);
         end
         default: begin
            x90_op = total_ff;
         end
      endcase
      x90 = times90(x90_op);
      if ((state_ff == S_CMP_END) || (state_ff == S_CMP_START) || (state_ff == S_ADJ)) begin
         sub_b = SUB_W'(x90);
      end
      diff = sub_a - sub_b;
   end

   always_comb begin
      state_in       = state_ff;
      cut_en_in      = cut_en_ff;
      load_cnt_in    = load_cnt_ff;
      read_idx_in    = read_idx_ff;
      origin_seen_in = origin_seen_ff;
      origin_in      = origin_ff;
      prev_in        = prev_ff;
      total_in       = total_ff;
      pcr_in         = pcr_ff;
      pid_in         = pid_ff;
      elapsed_in     = elapsed_ff;
      end_in         = end_ff;
      end_open_in    = end_open_ff;
      res_pass_in    = res_pass_ff;
      res_adj_in     = res_adj_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      wr_en          = 1'b0;
      wr_addr        = load_cnt_ff[AW-1:0];
      rd_en          = 1'b0;
      rd_addr        = read_idx_ff[AW-1:0];
      out_load       = 1'b0;

      if (csr_valid && csr_ready) begin
         cut_en_in = csr_cut_enable;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               pcr_in = req_pcr_value;
               pid_in = req_packet_id;
               unique case (req_command)
                  CMD_LOAD: begin
                     if (load_cnt_ff < CW'(CUT_DEPTH)) begin
                        wr_en       = 1'b1;
                        load_cnt_in = load_cnt_ff + CW'(1);
                     end
                  end
                  CMD_RESTART: begin
                     load_cnt_in    = '0;
                     read_idx_in    = '0;
                     origin_seen_in = 1'b0;
                     origin_in      = '0;
                     prev_in        = '0;
                     total_in       = '0;
                  end
                  CMD_PROCESS: begin
                     if (!cut_en_ff) begin
                        res_pass_in = 1'b1;
                        res_adj_in  = req_pcr_valid ? req_pcr_value : '0;
                        state_in    = S_OUT;
                     end else if (!req_pcr_valid) begin
                        res_pass_in = 1'b0;
                        res_adj_in  = '0;
                        state_in    = S_OUT;
                     end else begin
                        state_in = S_ORIGIN;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_ORIGIN: begin
            if (!origin_seen_ff) begin
               origin_seen_in = 1'b1;
               origin_in      = pcr_ff;
               prev_in        = pcr_ff;
               state_in       = S_ELAPSED;
            end else if (diff[PCR_W-1]) begin
               // step backward of half the wrap or more
               res_pass_in = 1'b0;
               res_adj_in  = '0;
               state_in    = S_OUT;
            end else begin
               prev_in  = pcr_ff;
               state_in = S_ELAPSED;
            end
         end
         S_ELAPSED: begin
            elapsed_in = diff[PCR_W-1:0];
            state_in   = S_RD_END;
         end
         S_RD_END: begin
            if (({1'b0, read_idx_ff} + (CW+1)'(2)) <= limit) begin
               end_open_in = (idx_next >= load_cnt_ff);
               rd_en       = 1'b1;
               rd_addr     = idx_next[AW-1:0];
               state_in    = S_CMP_END;
            end else begin
               state_in = S_RD_START;
            end
         end
         S_CMP_END: begin
            // end*90 <= elapsed ticks is the same as end <= elapsed ms
            if (!diff[SUB_W-1]) begin
               end_in   = end_val;
               rd_en    = 1'b1;
               rd_addr  = read_idx_ff[AW-1:0];
               state_in = S_ACC;
            end else begin
               state_in = S_RD_START;
            end
         end
         S_ACC: begin
            total_in    = total_ff + end_ff - rd_data_ff;
            read_idx_in = read_idx_ff + CW'(2);
            state_in    = S_RD_END;
         end
         S_RD_START: begin
            if (({1'b0, read_idx_ff} < limit) && (read_idx_ff < CW'(CUT_DEPTH))) begin
               rd_en    = 1'b1;
               rd_addr  = read_idx_ff[AW-1:0];
               state_in = S_CMP_START;
            end else begin
               state_in = S_ADJ;
            end
         end
         S_CMP_START: begin
            if (!diff[SUB_W-1]) begin
               res_pass_in = 1'b0;
               res_adj_in  = '0;
               state_in    = S_OUT;
            end else begin
               state_in = S_ADJ;
            end
         end
         S_ADJ: begin
            res_pass_in = 1'b1;
            res_adj_in  = diff[PCR_W-1:0];
            state_in    = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               out_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         cut_en_ff      <= 1'b0;
         load_cnt_ff    <= '0;
         read_idx_ff    <= '0;
         origin_seen_ff <= 1'b0;
         origin_ff      <= '0;
         prev_ff        <= '0;
         total_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         cut_en_ff      <= cut_en_in;
         load_cnt_ff    <= load_cnt_in;
         read_idx_ff    <= read_idx_in;
         origin_seen_ff <= origin_seen_in;
         origin_ff      <= origin_in;
         prev_ff        <= prev_in;
         total_ff       <= total_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pcr_ff      <= pcr_in;
      pid_ff      <= pid_in;
      elapsed_ff  <= elapsed_in;
      end_ff      <= end_in;
      end_open_ff <= end_open_in;
      res_pass_ff <= res_pass_in;
      res_adj_ff  <= res_adj_in;
      if (out_load) begin
         rsp_pass_ff <= res_pass_ff;
         rsp_pid_ff  <= pid_ff;
         rsp_adj_ff  <= res_adj_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         cut_mem[wr_addr] <= req_cut_time_ms;
      end
      if (rd_en) begin
         rd_data_ff <= cut_mem[rd_addr];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pass_item     = rsp_pass_ff;
   assign rsp_out_packet_id = rsp_pid_ff;
   assign rsp_adjusted_pcr  = rsp_adj_ff;

   a_idx_even: assert property (@(posedge clock) disable iff (reset)
      read_idx_ff[0] == 1'b0)
      else $error("read index left a start entry");

   a_idx_limit: assert property (@(posedge clock) disable iff (reset)
      {1'b0, read_idx_ff} <= limit)
      else $error("read index ran past the loaded intervals");

   a_load_bound: assert property (@(posedge clock) disable iff (reset)
      load_cnt_ff <= CW'(CUT_DEPTH))
      else $error("load count beyond table depth");

   a_out_issue: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT) && (!rsp_valid_ff || !rsp_stall) |=> rsp_valid && !req_stall)
      else $error("finished item not presented");

   a_drop_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_pass_item |-> rsp_adjusted_pcr == '0)
      else $error("dropped item carries a timestamp");

endmodule

// ===== tb/tb_pcr_cut_segment_gate_top.sv =====
module tb_pcr_cut_segment_gate_top;
   import pcsg_pkg::*;

   localparam int TBL_DEPTH = CUT_DEPTH_DEFAULT;
   localparam int TBL_AW = $clog2(TBL_DEPTH);
   localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;
   localparam int SETTLE_CYCLES = 16;
   localparam logic [PCR_W-1:0] ORIGIN = 33'h1_FFFF_FF00;
   localparam logic [PCR_W-1:0] HALF_WRAP = 33'h1_0000_0000;

   typedef struct {
      logic [CMD_W-1:0] cmd;
      logic             pv;
      logic [PCR_W-1:0] pcr;
      logic [PID_W-1:0] pid;
      logic [CUT_W-1:0] cut;
   } req_item_type;

   typedef struct {
      logic             keep;
      logic [PID_W-1:0] pid;
      logic [PCR_W-1:0] pcr;
   } gate_result_type;

   logic clock = 1'b0;
   logic reset;

   logic             req_valid;
   logic             req_stall;
   logic [CMD_W-1:0] req_command;
   logic             req_pcr_valid;
   logic [PCR_W-1:0] req_pcr_value;
   logic [PID_W-1:0] req_packet_id;
   logic [CUT_W-1:0] req_cut_time_ms;

   logic             rsp_valid;
   logic             rsp_stall;
   logic             rsp_pass_item;
   logic [PID_W-1:0] rsp_out_packet_id;
   logic [PCR_W-1:0] rsp_adjusted_pcr;

   logic csr_valid;
   logic csr_ready;
   logic csr_cut_enable;

   req_item_type    req_item_q[$];
   gate_result_type gate_result_q[$];
   req_item_type    cur_item;
   bit              req_taken;
   int unsigned     queued_items;
   int unsigned     mismatch_cnt;
   int unsigned     send_idle_pct;
   int unsigned     recv_stall_pct;

   // predictor state
   logic [CUT_W-1:0] cut_tbl [TBL_DEPTH];
   int unsigned      n_loaded  = 0;
   int unsigned      rd_idx    = 0;
   bit               org_seen  = 0;
   logic [PCR_W-1:0] org_pcr   = '0;
   logic [PCR_W-1:0] prev_pcr  = '0;
   logic [CUT_W-1:0] cut_total = '0;
   bit               cut_en    = 0;

   pcr_cut_segment_gate_top #(
      .CUT_DEPTH(TBL_DEPTH)
   ) u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_command       (req_command),
      .req_pcr_valid     (req_pcr_valid),
      .req_pcr_value     (req_pcr_value),
      .req_packet_id     (req_packet_id),
      .req_cut_time_ms   (req_cut_time_ms),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_pass_item     (rsp_pass_item),
      .rsp_out_packet_id (rsp_out_packet_id),
      .rsp_adjusted_pcr  (rsp_adjusted_pcr),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_cut_enable    (csr_cut_enable)
   );

   always #5 clock = ~clock;

   task automatic report_mismatch(input string msg);
      $display("%0t: mismatch: %s", $time, msg);
      mismatch_cnt++;
   endtask

   // end of the interval starting at entry s; an unpaired start runs open
   function automatic logic [63:0] interval_end(input int unsigned s);
      if (s + 1 < n_loaded && s + 1 < TBL_DEPTH)
         return 64'(cut_tbl[TBL_AW'(s + 1)]);
      return 64'(OPEN_END_MS);
   endfunction

   task automatic gate_predict(input req_item_type it);
      gate_result_type  r;
      logic [PCR_W-1:0] step;
      logic [PCR_W-1:0] elapsed;
      logic [63:0]      ms;
      int unsigned      lim;
      case (it.cmd)
         CMD_LOAD: begin
            if (n_loaded < TBL_DEPTH) begin
               cut_tbl[TBL_AW'(n_loaded)] = it.cut;
               n_loaded++;
            end
         end
         CMD_RESTART: begin
            n_loaded  = 0;
            rd_idx    = 0;
            org_seen  = 0;
            org_pcr   = '0;
            prev_pcr  = '0;
            cut_total = '0;
         end
         CMD_PROCESS: begin
            r.keep = 1'b0;
            r.pid  = it.pid;
            r.pcr  = '0;
            if (!cut_en) begin
               r.keep = 1'b1;
               r.pcr  = it.pv ? it.pcr : '0;
            end else if (it.pv) begin
               if (!org_seen) begin
                  org_seen = 1;
                  org_pcr  = it.pcr;
                  prev_pcr = it.pcr;
               end
               step = it.pcr - prev_pcr;
               // a step of half the wrap or more counts as going backward
               if (!step[PCR_W-1]) begin
                  prev_pcr = it.pcr;
                  elapsed  = it.pcr - org_pcr;
                  ms       = 64'(elapsed) / 64'd90;
                  lim      = n_loaded + (n_loaded & 1);
                  while (rd_idx + 2 <= lim && interval_end(rd_idx) <= ms) begin
                     cut_total = CUT_W'(64'(cut_total) + interval_end(rd_idx)
                                        - 64'(cut_tbl[TBL_AW'(rd_idx)]));
                     rd_idx += 2;
                  end
                  if (!(rd_idx < lim && 64'(cut_tbl[TBL_AW'(rd_idx)]) <= ms)) begin
                     r.keep = 1'b1;
                     r.pcr  = PCR_W'(64'(it.pcr) - 64'(cut_total) * 64'd90);
                  end
               end
            end
            gate_result_q = {gate_result_q, r};
         end
         default: ;
      endcase
   endtask

   function automatic void push_item(input logic [CMD_W-1:0] c, input logic pv,
                                     input logic [PCR_W-1:0] p,
                                     input logic [PID_W-1:0] id,
                                     input logic [CUT_W-1:0] ct);
      req_item_type it;
      it.cmd = c;
      it.pv  = pv;
      it.pcr = p;
      it.pid = id;
      it.cut = ct;
      req_item_q = {req_item_q, it};
      if (c != CMD_UNKNOWN)
         queued_items++;
   endfunction

   // an optional restart, a cut list, then a timestamp run through it with some noise
   task automatic add_sequence();
      int unsigned      kind;
      int unsigned      n_cuts;
      int unsigned      n_steps;
      int unsigned      r;
      logic [CUT_W-1:0] t;
      logic [PCR_W-1:0] pcr;
      kind = $urandom_range(0, 99);
      if ($urandom_range(0, 7) != 0)
         push_item(CMD_RESTART, 1'($urandom()), PCR_W'({$urandom(), $urandom()}),
                   PID_W'($urandom()), CUT_W'($urandom()));
      n_cuts = (kind < 6) ? $urandom_range(60, 70) : $urandom_range(0, 9);
      t = CUT_W'($urandom_range(0, 400));
      for (int i = 0; i < n_cuts; i++) begin
         if (kind >= 6 && kind < 16)
            t = CUT_W'($urandom());
         else
            t = t + CUT_W'($urandom_range(0, (kind < 6) ? 40 : 400));
         push_item(CMD_LOAD, 1'($urandom()), PCR_W'({$urandom(), $urandom()}),
                   PID_W'($urandom()), t);
      end
      pcr = PCR_W'({$urandom(), $urandom()});
      n_steps = $urandom_range(4, 30);
      for (int i = 0; i < n_steps; i++) begin
         r = $urandom_range(0, 99);
         if (r < 4)
            push_item(CMD_PROCESS, 1'b0, PCR_W'({$urandom(), $urandom()}),
                      PID_W'($urandom()), CUT_W'($urandom()));
         else if (r < 7)
            push_item(CMD_PROCESS, 1'b1, pcr - PCR_W'($urandom_range(1, 9000)),
                      PID_W'($urandom()), CUT_W'($urandom()));
         else if (r < 9)
            push_item(CMD_PROCESS, 1'b1,
                      pcr + HALF_WRAP + PCR_W'($urandom_range(0, 1000)),
                      PID_W'($urandom()), CUT_W'($urandom()));
         else if (r < 11)
            push_item(CMD_UNKNOWN, 1'($urandom()), PCR_W'({$urandom(), $urandom()}),
                      PID_W'($urandom()), CUT_W'($urandom()));
         else if (r < 13) begin
            t = t + CUT_W'($urandom_range(0, 400));
            push_item(CMD_LOAD, 1'($urandom()), PCR_W'({$urandom(), $urandom()}),
                      PID_W'($urandom()), t);
         end else begin
            // largest forward step now and then, otherwise up to 250 ms
            if (r < 14)
               pcr = pcr + (HALF_WRAP - 1);
            else
               pcr = pcr + PCR_W'($urandom_range(0, 90 * 250));
            push_item(CMD_PROCESS, 1'b1, pcr, PID_W'($urandom()), CUT_W'($urandom()));
         end
      end
   endtask

   task automatic add_random(input int unsigned n);
      int unsigned target;
      target = queued_items + n;
      while (queued_items < target)
         add_sequence();
   endtask

   task automatic drain();
      do @(posedge clock);
      while (req_item_q.size() != 0 || req_valid || gate_result_q.size() != 0);
      // loads and restarts give no result and may still be in flight
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_enable(input logic v);
      @(negedge clock);
      csr_valid      <= 1'b1;
      csr_cut_enable <= v;
      do @(posedge clock);
      while (!csr_ready);
      cut_en = v;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
         if (!req_valid || req_taken) begin
            req_taken = 0;
            if (req_item_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               cur_item = req_item_q.pop_front();
               req_valid       <= 1'b1;
               req_command     <= cur_item.cmd;
               req_pcr_valid   <= cur_item.pv;
               req_pcr_value   <= cur_item.pcr;
               req_packet_id   <= cur_item.pid;
               req_cut_time_ms <= cur_item.cut;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor and checker
   always @(posedge clock) begin
      gate_result_type exp_r;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            gate_predict(cur_item);
            req_taken = 1;
         end
         if (rsp_valid && !rsp_stall) begin
            if (gate_result_q.size() == 0) begin
               report_mismatch("result with no item outstanding");
            end else begin
               exp_r = gate_result_q.pop_front();
               if (rsp_pass_item !== exp_r.keep)
                  report_mismatch($sformatf("pass_item %b, want %b",
                                            rsp_pass_item, exp_r.keep));
               if (rsp_out_packet_id !== exp_r.pid)
                  report_mismatch($sformatf("out_packet_id %h, want %h",
                                            rsp_out_packet_id, exp_r.pid));
               if (rsp_adjusted_pcr !== exp_r.pcr)
                  report_mismatch($sformatf("adjusted_pcr %h, want %h",
                                            rsp_adjusted_pcr, exp_r.pcr));
            end
         end
      end
   end

   initial begin
      #10_000_000;
      $display("tb_pcr_cut_segment_gate_top NOT OK");
      $finish;
   end

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_command     = CMD_PROCESS;
      req_pcr_valid   = 1'b0;
      req_pcr_value   = '0;
      req_packet_id   = '0;
      req_cut_time_ms = '0;
      rsp_stall       = 1'b0;
      csr_valid       = 1'b0;
      csr_cut_enable  = 1'b0;
      req_taken       = 0;
      queued_items    = 0;
      mismatch_cnt    = 0;
      send_idle_pct   = 17;
      recv_stall_pct  = 83;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // cutting off: everything passes, a missing timestamp comes out as zero
      write_enable(1'b0);
      push_item(CMD_PROCESS, 1'b1, '1, '1, '1);
      push_item(CMD_PROCESS, 1'b0, 33'h0_AAAA_5555, '0, '0);
      push_item(CMD_UNKNOWN, 1'b1, '1, '1, '1);
      drain();

      // cutting on: [100,200], unordered [300,250], unpaired start at 400
      write_enable(1'b1);
      push_item(CMD_RESTART, 1'b0, '0, '0, '0);
      push_item(CMD_LOAD, 1'b0, '0, '0, 29'd100);
      push_item(CMD_LOAD, 1'b0, '0, '0, 29'd200);
      push_item(CMD_LOAD, 1'b0, '0, '0, 29'd300);
      push_item(CMD_LOAD, 1'b0, '0, '0, 29'd250);
      push_item(CMD_LOAD, 1'b0, '0, '0, 29'd400);
      push_item(CMD_PROCESS, 1'b0, ORIGIN, 13'h0155, '0);
      push_item(CMD_PROCESS, 1'b1, ORIGIN, '0, '0);
      push_item(CMD_PROCESS, 1'b1, ORIGIN + PCR_W'(90 * 50), 13'h0AAA, '0);
      push_item(CMD_PROCESS, 1'b1, ORIGIN + PCR_W'(90 * 150), 13'h1555, '0);
      push_item(CMD_PROCESS, 1'b1, ORIGIN + PCR_W'(90 * 149), 13'h0001, '0);
      push_item(CMD_PROCESS, 1'b1, ORIGIN + PCR_W'(90 * 220), 13'h0002, '0);
      push_item(CMD_PROCESS, 1'b1, ORIGIN + PCR_W'(90 * 220) + HALF_WRAP, 13'h0003, '0);
      push_item(CMD_PROCESS, 1'b1, ORIGIN + PCR_W'(90 * 260), 13'h0004, '0);
      push_item(CMD_PROCESS, 1'b1, ORIGIN + PCR_W'(90 * 500), 13'h0005, '0);
      push_item(CMD_LOAD, 1'b1, '1, '1, 29'd359999999);
      push_item(CMD_LOAD, 1'b1, '1, '1, 29'd0);
      push_item(CMD_PROCESS, 1'b1, ORIGIN + PCR_W'(90 * 500) + (HALF_WRAP - 1),
                13'h0006, '0);
      push_item(CMD_UNKNOWN, 1'b0, '0, '0, '0);
      push_item(CMD_PROCESS, 1'b1, '1, '1, '1);
      add_random(550);
      drain();

      write_enable(1'b0);
      add_random(100);
      drain();

      send_idle_pct  = 83;
      recv_stall_pct = 17;
      write_enable(1'b1);
      add_random(600);
      drain();

      send_idle_pct  = 0;
      recv_stall_pct = 0;
      add_random(350);
      drain();
      write_enable(1'b0);
      add_random(60);
      drain();
      write_enable(1'b1);
      add_random(60);
      drain();

      if (mismatch_cnt == 0)
         $display("tb_pcr_cut_segment_gate_top OK");
      else
         $display("tb_pcr_cut_segment_gate_top NOT OK");
      $finish;
   end

endmodule
